// ----- sv/sfum_pkg.sv -----
// shared types, codes and helpers for the stream find-until matcher
// no dependencies; imported by every module of the block except the checker
`default_nettype none

package sfum_pkg;

   localparam int MaxPatternDefault = 8;
   localparam int PatW              = 64;
   localparam int PatBytes          = PatW / 8;
   localparam int LenW              = 4;
   localparam int ByteIdxW          = 5;
   localparam int CsrIdxW           = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TARGET_PATTERN = 3'd0,
      CSR_TARGET_LENGTH  = 3'd1,
      CSR_STOP_PATTERN   = 3'd2,
      CSR_STOP_LENGTH    = 3'd3,
      CSR_STOP_ENABLE    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_SEARCHING = 2'd0,
      STATUS_TARGET    = 2'd1,
      STATUS_STOP      = 2'd2,
      STATUS_TIMEOUT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [PatW-1:0] target_pattern;
      logic [LenW-1:0] target_length;
      logic [PatW-1:0] stop_pattern;
      logic [LenW-1:0] stop_length;
      logic            stop_enable;
   } cfg_type;

   // candidate prefix length under test and the progress it falls back from
   typedef struct packed {
      logic [LenW-1:0] cand;
      logic [LenW-1:0] orig;
   } step_type;

   // bytes beyond the register read as zero
   function automatic logic [7:0] pat_byte(input logic [PatW-1:0] pat,
                                           input logic [ByteIdxW-1:0] idx);
      logic [PatW-1:0] shifted;
      shifted = pat >> {idx[2:0], 3'b000};
      if (idx >= ByteIdxW'(PatBytes)) begin
         return 8'h00;
      end
      return shifted[7:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/sfum_csr.sv -----
// configuration register bank of the matcher
// depends on sfum_pkg
`default_nettype none

module sfum_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [sfum_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [sfum_pkg::PatW-1:0]    csr_data,
   output sfum_pkg::cfg_type                 cfg
);
   import sfum_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_PATTERN: cfg_in.target_pattern = csr_data;
            CSR_TARGET_LENGTH:  cfg_in.target_length  = csr_data[LenW-1:0];
            CSR_STOP_PATTERN:   cfg_in.stop_pattern   = csr_data;
            CSR_STOP_LENGTH:    cfg_in.stop_length    = csr_data[LenW-1:0];
            CSR_STOP_ENABLE:    cfg_in.stop_enable    = csr_data[0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/sfum_prefix_unit.sv -----
// shared compare unit: tests one candidate prefix length per cycle
// depends on sfum_pkg
`default_nettype none

module sfum_prefix_unit #(
   parameter int MAX_PATTERN = sfum_pkg::MaxPatternDefault
) (
   input  wire logic [sfum_pkg::PatW-1:0] pattern,
   input  wire logic [7:0]                data_byte,
   input  wire sfum_pkg::step_type        step,
   output logic                           hit
);
   import sfum_pkg::*;

   logic [LenW-1:0]        diff;
   logic [MAX_PATTERN-1:0] lane_ok;

   assign diff = step.orig - step.cand;

   // lane i compares pattern byte i with byte i+diff when i lies in the prefix
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (ByteIdxW'(i) < {1'b0, step.cand}) begin
            lane_ok[i] = pat_byte(pattern, ByteIdxW'(i))
                         == pat_byte(pattern, ByteIdxW'(i) + {1'b0, diff});
         end else begin
            lane_ok[i] = 1'b1;
         end
      end
   end

   assign hit = (data_byte == pat_byte(pattern, {1'b0, step.cand})) && (&lane_ok);

endmodule

`default_nettype wire

// ----- sv/stream_find_until_matcher_unit.sv -----
// top level of the stream find-until matcher: request sequencer and progress state
// depends on sfum_pkg, sfum_csr, sfum_prefix_unit
// sequence: EVAL settles zero lengths and timeouts; else WALK runs compare steps, one per
//   cycle on the shared prefix compare unit, for the target and, if enabled and the target is
//   not complete, for the terminator, each from its progress down to a hit or zero; DONE
//   registers the result once any earlier one is taken, and the next request is taken from then
// reset: synchronous, clears configuration, both progress counters and the result valid flag
`default_nettype none

module stream_find_until_matcher_unit #(
   parameter int MAX_PATTERN = sfum_pkg::MaxPatternDefault
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,   // [7:0] data_byte
   input  wire logic                         req_tuser,   // [0] timed_out
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [1:0] status, [7:2] zero
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [sfum_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [sfum_pkg::PatW-1:0]    csr_data
);
   import sfum_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_WALK = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   localparam logic [LenW:0] MaxLen = (LenW+1)'(MAX_PATTERN);

   cfg_type          cfg;
   state_type        state_ff, state_in;
   logic [7:0]       byte_ff, byte_in;
   logic             to_ff, to_in;
   logic             sel_stop_ff, sel_stop_in;
   step_type         step_ff, step_in;
   status_type       status_ff, status_in;
   logic [LenW-1:0]  tprog_ff, tprog_in;
   logic [LenW-1:0]  sprog_ff, sprog_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic [LenW-1:0]  tlen, slen, act_len, t_start, s_start, new_prog;
   logic [PatW-1:0]  act_pat;
   logic             hit, walk_last, walk_done;

   sfum_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfum_prefix_unit #(.MAX_PATTERN(MAX_PATTERN)) u_prefix (
      .pattern   (act_pat),
      .data_byte (byte_ff),
      .step      (step_ff),
      .hit       (hit)
   );

   assign tlen = ({1'b0, cfg.target_length} > MaxLen) ? MaxLen[LenW-1:0] : cfg.target_length;
   assign slen = ({1'b0, cfg.stop_length} > MaxLen) ? MaxLen[LenW-1:0] : cfg.stop_length;

   // stale progress at or above the length restarts from zero
   assign t_start = (tprog_ff >= tlen) ? '0 : tprog_ff;
   assign s_start = (sprog_ff >= slen) ? '0 : sprog_ff;

   assign act_pat   = sel_stop_ff ? cfg.stop_pattern : cfg.target_pattern;
   assign act_len   = sel_stop_ff ? slen : tlen;
   assign new_prog  = hit ? step_ff.cand + 1'b1 : '0;
   assign walk_last = hit || (step_ff.cand == '0);
   assign walk_done = (new_prog == act_len);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_status_ff};

   always_comb begin
      state_in      = state_ff;
      byte_in       = byte_ff;
      to_in         = to_ff;
      sel_stop_in   = sel_stop_ff;
      step_in       = step_ff;
      status_in     = status_ff;
      tprog_in      = tprog_ff;
      sprog_in      = sprog_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata;
               to_in    = req_tuser;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (tlen == '0) begin
               status_in = STATUS_TARGET;
               state_in  = ST_DONE;
            end else if (cfg.stop_enable && (slen == '0)) begin
               status_in = STATUS_STOP;
               state_in  = ST_DONE;
            end else if (to_ff) begin
               status_in = STATUS_TIMEOUT;
               state_in  = ST_DONE;
            end else begin
               step_in.cand = t_start;
               step_in.orig = t_start;
               sel_stop_in  = 1'b0;
               state_in     = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_last) begin
               if (!sel_stop_ff) begin
                  if (walk_done) begin
                     status_in = STATUS_TARGET;
                     state_in  = ST_DONE;
                  end else begin
                     tprog_in = new_prog;
                     if (cfg.stop_enable) begin
                        step_in.cand = s_start;
                        step_in.orig = s_start;
                        sel_stop_in  = 1'b1;
                     end else begin
                        status_in = STATUS_SEARCHING;
                        state_in  = ST_DONE;
                     end
                  end
               end else begin
                  sprog_in  = new_prog;
                  status_in = walk_done ? STATUS_STOP : STATUS_SEARCHING;
                  state_in  = ST_DONE;
               end
            end else begin
               step_in.cand = step_ff.cand - 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff != STATUS_SEARCHING) begin
                  tprog_in = '0;
                  sprog_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tprog_ff     <= '0;
         sprog_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tprog_ff     <= tprog_in;
         sprog_ff     <= sprog_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      to_ff         <= to_in;
      sel_stop_ff   <= sel_stop_in;
      step_ff       <= step_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

`default_nettype wire

// ----- sv/sfum_checker.sv -----
// port-level checks for the stream find-until matcher, bound to the top level
// depends on stream_find_until_matcher_unit port list
`default_nettype none

module sfum_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // padding bits of the result stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:2] == 6'b000000))
      else $error("result padding not zero");

   // right after a request is taken, neither a result rises nor is a new request taken
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid) && !req_tready)
      else $error("result or new request too early after a request");

endmodule

bind stream_find_until_matcher_unit sfum_checker u_sfum_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- bench/stream_find_until_matcher_unit_tb.sv -----
// self-checking bench for stream_find_until_matcher_unit: directed cases, then random phases
// depends on sfum_pkg and the rtl of the block; a scoreboard class predicts each status
`timescale 1ns / 1ps

module stream_find_until_matcher_unit_tb;
   import sfum_pkg::*;

   localparam int CycleLimit  = 600000;
   localparam int SettleCycles = 2 * MaxPatternDefault + 6;

   class match_tracker;
      cfg_type         cfg;
      logic [LenW-1:0] target_prog;
      logic [LenW-1:0] stop_prog;
      status_type      pending[$];
      int              errors;

      function new();
         cfg         = '0;
         target_prog = '0;
         stop_prog   = '0;
         errors      = 0;
      endfunction

      static function logic [7:0] byte_at(logic [PatW-1:0] pat, int unsigned i);
         if (i >= PatBytes) begin
            return 8'h00;
         end
         return pat[8*i +: 8];
      endfunction

      static function int unsigned clamp_len(logic [LenW-1:0] len);
         if (len > MaxPatternDefault) begin
            return MaxPatternDefault;
         end
         return 32'(len);
      endfunction

      function void write_reg(csr_index_type idx, logic [PatW-1:0] d);
         case (idx)
            CSR_TARGET_PATTERN: cfg.target_pattern = d;
            CSR_TARGET_LENGTH:  cfg.target_length  = d[LenW-1:0];
            CSR_STOP_PATTERN:   cfg.stop_pattern   = d;
            CSR_STOP_LENGTH:    cfg.stop_length    = d[LenW-1:0];
            CSR_STOP_ENABLE:    cfg.stop_enable    = d[0];
            default: ;
         endcase
      endfunction

      // one byte against one pattern; falls back by direct prefix comparison
      function bit advance(input logic [PatW-1:0] pat, input int unsigned len,
                           input logic [LenW-1:0] prog_in, input logic [7:0] c,
                           output logic [LenW-1:0] prog_out);
         int unsigned idx;
         int unsigned orig;
         int unsigned diff;
         int unsigned i;
         idx = 32'(prog_in);
         if (idx >= len) idx = 0;
         if (c == byte_at(pat, idx)) begin
            idx++;
            prog_out = idx[LenW-1:0];
            return idx == len;
         end
         if (idx == 0) begin
            prog_out = '0;
            return 1'b0;
         end
         orig = idx;
         do begin
            idx--;
            if (c != byte_at(pat, idx)) continue;
            if (idx == 0) begin
               idx = 1;
               break;
            end
            diff = orig - idx;
            for (i = 0; i < idx && byte_at(pat, i) == byte_at(pat, i + diff); i++) begin
            end
            if (i == idx) begin
               idx++;
               break;
            end
         end while (idx > 0);
         prog_out = idx[LenW-1:0];
         return 1'b0;
      endfunction

      function void note_request(logic [7:0] c, logic to);
         int unsigned     tlen;
         int unsigned     slen;
         logic [LenW-1:0] next_prog;
         status_type      st;
         tlen = clamp_len(cfg.target_length);
         slen = clamp_len(cfg.stop_length);
         st   = STATUS_SEARCHING;
         if (tlen == 0) begin
            st = STATUS_TARGET;
         end else if (cfg.stop_enable && slen == 0) begin
            st = STATUS_STOP;
         end else if (to) begin
            st = STATUS_TIMEOUT;
         end else begin
            if (advance(cfg.target_pattern, tlen, target_prog, c, next_prog)) begin
               st = STATUS_TARGET;
            end
            target_prog = next_prog;
            if (st == STATUS_SEARCHING && cfg.stop_enable) begin
               if (advance(cfg.stop_pattern, slen, stop_prog, c, next_prog)) begin
                  st = STATUS_STOP;
               end
               stop_prog = next_prog;
            end
         end
         if (st != STATUS_SEARCHING) begin
            target_prog = '0;
            stop_prog   = '0;
         end
         pending.push_back(st);
      endfunction

      function void check_response(logic [7:0] tdata);
         status_type exp;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: response 0x%02h with no request pending", $time, tdata);
            return;
         end
         exp = pending.pop_front();
         if (tdata !== {6'b0, exp}) begin
            errors++;
            $display("%0t: status mismatch, expected %s (0x%02h), actual 0x%02h",
                     $time, exp.name(), {6'b0, exp}, tdata);
         end
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = 8'h00;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CsrIdxW-1:0]   csr_index  = '0;
   logic [PatW-1:0]      csr_data   = '0;

   match_tracker    tracker;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              cycle_count    = 0;
   logic [PatW-1:0] cur_tp;
   logic [PatW-1:0] cur_sp;
   int unsigned     cur_tl;
   int unsigned     cur_sl;
   logic            cur_en;

   stream_find_until_matcher_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("stream_find_until_matcher_unit_tb: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
   end

   task automatic send_request(input logic [7:0] c, input logic to);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= to;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(c, to);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [PatW-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, d);
   endtask

   task automatic configure(input logic [PatW-1:0] tp, input logic [LenW-1:0] tl,
                            input logic [PatW-1:0] sp, input logic [LenW-1:0] sl,
                            input logic en);
      drain();
      write_reg(CSR_TARGET_PATTERN, tp);
      write_reg(CSR_TARGET_LENGTH, PatW'(tl));
      write_reg(CSR_STOP_PATTERN, sp);
      write_reg(CSR_STOP_LENGTH, PatW'(sl));
      write_reg(CSR_STOP_ENABLE, PatW'(en));
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_tp = tp;
      cur_sp = sp;
      cur_tl = match_tracker::clamp_len(tl);
      cur_sl = match_tracker::clamp_len(sl);
      cur_en = en;
   endtask

   function automatic logic [PatW-1:0] make_pattern(int kind);
      logic [PatW-1:0] p;
      logic [7:0]      a;
      logic [7:0]      b;
      a = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      case (kind)
         0: for (int i = 0; i < PatBytes; i++) p[8*i +: 8] = $urandom_range(1) ? a : b;
         1: p = {$urandom, $urandom};
         2: p = '1;
         default: p = '0;
      endcase
      return p;
   endfunction

   task automatic send_noise(inout int count);
      send_request(8'($urandom_range(255)), $urandom_range(99) < 20);
      count++;
   endtask

   // mostly whole patterns with random breaks, the rest noise and timeouts
   task automatic run_items(input int n);
      int count;
      int r;
      int k;
      count = 0;
      while (count < n) begin
         r = $urandom_range(99);
         if (r < 50 && cur_tl > 0) begin
            for (int i = 0; i < cur_tl; i++)
               send_request(match_tracker::byte_at(cur_tp, i), 1'b0);
            count += cur_tl;
         end else if (r < 70 && cur_sl > 0) begin
            for (int i = 0; i < cur_sl; i++)
               send_request(match_tracker::byte_at(cur_sp, i), 1'b0);
            count += cur_sl;
         end else if (r < 88 && cur_tl > 1) begin
            k = $urandom_range(cur_tl - 1, 1);
            for (int i = 0; i < k; i++) send_request(match_tracker::byte_at(cur_tp, i), 1'b0);
            if ($urandom_range(1))
               send_request(match_tracker::byte_at(cur_tp, $urandom_range(cur_tl - 1)), 1'b0);
            else
               send_request(match_tracker::byte_at(cur_sp, $urandom_range(7)), 1'b0);
            count += k + 1;
         end else begin
            send_noise(count);
         end
      end
   endtask

   initial begin
      logic [PatW-1:0] tp;
      logic [PatW-1:0] sp;
      logic [LenW-1:0] tl;
      logic [LenW-1:0] sl;
      logic            en;
      int              n;
      tracker = new();
      cur_tp = '0;
      cur_sp = '0;
      cur_tl = 0;
      cur_sl = 0;
      cur_en = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero-length target wins over everything, timeouts included
      send_request(8'h00, 1'b0);
      send_request(8'hff, 1'b1);

      // enabled zero-length terminator
      configure(64'h4241, 4'd2, 64'h0, 4'd0, 1'b1);
      send_request(8'h41, 1'b0);
      send_request(8'h42, 1'b1);

      // timeout, then target taking priority over terminator on one byte
      configure(64'h4241, 4'd2, 64'h42, 4'd1, 1'b1);
      send_request(8'h41, 1'b1);
      send_request(8'h41, 1'b0);
      send_request(8'h42, 1'b0);
      send_request(8'h42, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(8'h42, 1'b0);

      // saturated length with all-ones pattern
      configure('1, 4'd12, '0, 4'd8, 1'b0);
      repeat (8) send_request(8'hff, 1'b0);
      send_request(8'h00, 1'b0);

      // stale progress after the length is lowered mid-search
      configure(64'h44434241, 4'd4, '0, 4'd8, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(8'h42, 1'b0);
      send_request(8'h43, 1'b0);
      configure(64'h44434241, 4'd2, '0, 4'd8, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(8'h42, 1'b0);

      for (int p = 0; p < 13; p++) begin
         tp = make_pattern($urandom_range(99) < 70 ? 0 : 1);
         sp = make_pattern($urandom_range(99) < 70 ? 0 : 1);
         tl = 4'($urandom_range(8, 1));
         sl = 4'($urandom_range(8, 1));
         en = 1'($urandom_range(1));
         n  = 165;
         case (p)
            0: begin tl = 4'd8; sl = 4'd8; en = 1'b1; end
            1: begin tl = 4'd1; sl = 4'd1; en = 1'b1; end
            2: begin tp = make_pattern(2); sp = make_pattern(3); tl = 4'd8; sl = 4'd8; en = 1'b1; end
            3: begin tl = 4'd15; sl = 4'd9; en = 1'b1; end
            4: en = 1'b0;
            5: begin tl = 4'd0; n = 60; end
            6: begin sl = 4'd0; en = 1'b1; n = 60; end
            default: ;
         endcase
         configure(tp, tl, sp, sl, en);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         run_items(n);
      end

      drain();
      if (tracker.errors == 0 && tracker.pending.size() == 0) begin
         $display("stream_find_until_matcher_unit_tb: done, clean");
      end else begin
         $display("stream_find_until_matcher_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
